// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the pixelation block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define BAP_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define BAP_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bap_pkg.sv =====
// Shared constants, types and codes of the block-average pixelation block.
`default_nettype none

package bap_pkg;

	localparam int BAP_BLOCK_SIZE = 8;
	localparam int BAP_MAX_WIDTH  = 4096;
	localparam int BAP_MAX_HEIGHT = 4096;
	localparam int DIM_RESET      = 4096;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 13;
	localparam int PIX_W      = 8;
	localparam int TILE_IDX_W = 9;
	localparam int AVG_W      = 8;
	localparam int COUNT_W    = 9;
	localparam int JOB_SUM_W  = 16;
	localparam int DVS_W      = COUNT_W + AVG_W - 1;
	localparam int NUM_CH     = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QLVL_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} bap_cfg_wr_t;

	typedef struct packed {
		logic [TILE_IDX_W-1:0]             tile_col;
		logic [TILE_IDX_W-1:0]             tile_row;
		logic [NUM_CH-1:0][JOB_SUM_W-1:0]  sum;
		logic [COUNT_W-1:0]                count;
		logic                              frame_done;
	} bap_job_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} bap_div_state_t;

endpackage

`default_nettype wire

// ===== rtl/bap_front.sv =====
// Front end: raster position tracking, row partial sums and the tile sum store.
`default_nettype none

module bap_front import bap_pkg::*; #(
	parameter int BLOCK_SIZE = BAP_BLOCK_SIZE,
	parameter int MAX_WIDTH  = BAP_MAX_WIDTH,
	parameter int MAX_HEIGHT = BAP_MAX_HEIGHT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bap_cfg_wr_t      cfg_wr,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [PIX_W-1:0] red_in,
	input  wire logic [PIX_W-1:0] green_in,
	input  wire logic [PIX_W-1:0] blue_in,
	output logic                  job_valid,
	input  wire logic             job_ready,
	output bap_job_t              job
);

	localparam int TILE_COLS = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int TILE_ROWS = (MAX_HEIGHT + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int TC_W      = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
	localparam int TR_W      = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int WD_W      = $clog2(MAX_WIDTH + 1);
	localparam int HD_W      = $clog2(MAX_HEIGHT + 1);
	localparam int WV_W      = (WD_W > CFG_DATA_W) ? WD_W : CFG_DATA_W;
	localparam int HV_W      = (HD_W > CFG_DATA_W) ? HD_W : CFG_DATA_W;
	localparam int IC_W      = $clog2(BLOCK_SIZE);
	localparam int TN_W      = $clog2(BLOCK_SIZE + 1);
	localparam int PART_W    = $clog2(BLOCK_SIZE * 255 + 1);
	localparam int SUM_W     = $clog2(BLOCK_SIZE * BLOCK_SIZE * 255 + 1);
	localparam int W_RST     = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;
	localparam int H_RST     = (MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET;

	logic [WD_W-1:0]  width_q;
	logic [HD_W-1:0]  height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [IC_W-1:0]  in_col_q;
	logic [IC_W-1:0]  in_row_q;
	logic [TC_W-1:0]  tc_q;
	logic [TR_W-1:0]  tr_q;
	logic [NUM_CH-1:0][PART_W-1:0] part_q;

	logic                          valid_s1;
	logic [TC_W-1:0]               tc_s1;
	logic [TR_W-1:0]               tr_s1;
	logic [NUM_CH-1:0][PART_W-1:0] part_s1;
	logic                          row0_s1;
	logic                          lct_s1;
	logic                          lrt_s1;
	logic [COUNT_W-1:0]            cnt_s1;
	logic                          fd_s1;
	logic [NUM_CH-1:0][SUM_W-1:0]  rd_s1;

	logic [NUM_CH-1:0][SUM_W-1:0] store_mem [TILE_COLS];

	logic [WV_W-1:0]               wv;
	logic [HV_W-1:0]               hv;
	logic [WD_W-1:0]               width_new;
	logic [HD_W-1:0]               height_new;
	logic [NUM_CH-1:0][PIX_W-1:0]  pix;
	logic [NUM_CH-1:0][PART_W-1:0] part_new;
	logic [NUM_CH-1:0][SUM_W-1:0]  tsum;
	logic                          accept;
	logic                          last_col;
	logic                          last_row;
	logic                          lct;
	logic                          lrt;
	logic [COUNT_W-1:0]            cnt;
	logic                          emit;
	logic                          s1_adv;
	logic                          wr_en;

	// Clamp register writes: zero means one, oversize saturates.
	always_comb begin
		wv = WV_W'(cfg_wr.data);
		hv = HV_W'(cfg_wr.data);
		if (wv == '0) begin
			width_new = WD_W'(1);
		end else if (wv > WV_W'(MAX_WIDTH)) begin
			width_new = WD_W'(MAX_WIDTH);
		end else begin
			width_new = WD_W'(wv);
		end
		if (hv == '0) begin
			height_new = HD_W'(1);
		end else if (hv > HV_W'(MAX_HEIGHT)) begin
			height_new = HD_W'(MAX_HEIGHT);
		end else begin
			height_new = HD_W'(hv);
		end
	end

	assign pix      = {blue_in, green_in, red_in};
	assign last_col = (WD_W'(col_q) + WD_W'(1)) == width_q;
	assign last_row = (HD_W'(row_q) + HD_W'(1)) == height_q;
	assign lct      = last_col || (in_col_q == IC_W'(BLOCK_SIZE - 1));
	assign lrt      = last_row || (in_row_q == IC_W'(BLOCK_SIZE - 1));
	// At a tile's closing pixel the tile is (in_col+1) x (in_row+1) pixels.
	assign cnt      = COUNT_W'(TN_W'(in_col_q) + TN_W'(1))
	                * COUNT_W'(TN_W'(in_row_q) + TN_W'(1));

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			part_new[c] = ((in_col_q == '0) ? '0 : part_q[c]) + PART_W'(pix[c]);
			tsum[c]     = row0_s1 ? SUM_W'(part_s1[c])
			                      : rd_s1[c] + SUM_W'(part_s1[c]);
		end
	end

	assign emit      = valid_s1 && lct_s1 && lrt_s1;
	assign s1_adv    = !emit || job_ready;
	assign wr_en     = valid_s1 && lct_s1 && s1_adv;
	assign in_ready  = !valid_s1 || s1_adv;
	assign accept    = in_valid && in_ready;
	assign job_valid = emit;

	always_comb begin
		job.tile_col   = TILE_IDX_W'(tc_s1);
		job.tile_row   = TILE_IDX_W'(tr_s1);
		job.count      = cnt_s1;
		job.frame_done = fd_s1;
		for (int c = 0; c < NUM_CH; c++) begin
			job.sum[c] = JOB_SUM_W'(tsum[c]);
		end
	end

	// Position, partial sums and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WD_W'(W_RST);
			height_q <= HD_W'(H_RST);
			col_q    <= '0;
			row_q    <= '0;
			in_col_q <= '0;
			in_row_q <= '0;
			tc_q     <= '0;
			tr_q     <= '0;
			part_q   <= '0;
		end else if (cfg_wr.we) begin
			if (cfg_wr.index == REG_IMAGE_WIDTH || cfg_wr.index == REG_IMAGE_HEIGHT) begin
				col_q    <= '0;
				row_q    <= '0;
				in_col_q <= '0;
				in_row_q <= '0;
				tc_q     <= '0;
				tr_q     <= '0;
				part_q   <= '0;
			end
			if (cfg_wr.index == REG_IMAGE_WIDTH) begin
				width_q <= width_new;
			end
			if (cfg_wr.index == REG_IMAGE_HEIGHT) begin
				height_q <= height_new;
			end
		end else if (accept) begin
			part_q <= part_new;
			if (last_col) begin
				col_q    <= '0;
				in_col_q <= '0;
				tc_q     <= '0;
				if (last_row) begin
					row_q    <= '0;
					in_row_q <= '0;
					tr_q     <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					if (in_row_q == IC_W'(BLOCK_SIZE - 1)) begin
						in_row_q <= '0;
						tr_q     <= tr_q + TR_W'(1);
					end else begin
						in_row_q <= in_row_q + IC_W'(1);
					end
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				if (in_col_q == IC_W'(BLOCK_SIZE - 1)) begin
					in_col_q <= '0;
					tc_q     <= tc_q + TC_W'(1);
				end else begin
					in_col_q <= in_col_q + IC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tc_s1   <= tc_q;
			tr_s1   <= tr_q;
			part_s1 <= part_new;
			row0_s1 <= (in_row_q == '0);
			lct_s1  <= lct;
			lrt_s1  <= lrt;
			cnt_s1  <= cnt;
			fd_s1   <= last_col && last_row;
		end
	end

	// Tile sum store: read at accept, written back from stage 1 when it advances with a
	// row-segment closing pixel; forward a write that lands on the address being read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[tc_s1] <= tsum;
		end
		if (accept) begin
			if (wr_en && tc_s1 == tc_q) begin
				rd_s1 <= tsum;
			end else begin
				rd_s1 <= store_mem[tc_q];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bap_fifo.sv =====
// Short queue of completed-tile jobs between the front end and the divider.
`default_nettype none

module bap_fifo import bap_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire bap_job_t     push_job,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output bap_job_t          pop_job,
	output logic [QLVL_W-1:0] level
);

	bap_job_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QLVL_W-1:0]   level_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = level_q != QLVL_W'(QUEUE_DEPTH);
	assign pop_valid  = level_q != '0;
	assign pop_job    = slot_q[rptr_q];
	assign level      = level_q;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + QLVL_W'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - QLVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bap_divider.sv =====
// Back end: three-lane restoring divider, two quotient bits per cycle, and result word.
`default_nettype none

module bap_divider import bap_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   job_valid,
	output logic                        job_ready,
	input  wire bap_job_t               job,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [TILE_IDX_W-1:0]       tile_col,
	output logic [TILE_IDX_W-1:0]       tile_row,
	output logic [AVG_W-1:0]            avg_red,
	output logic [AVG_W-1:0]            avg_grn,
	output logic [AVG_W-1:0]            avg_blu,
	output logic                        frame_done
);

	localparam int STEPS  = AVG_W / 2;
	localparam int STEP_W = $clog2(STEPS);

	bap_div_state_t state_q;
	bap_div_state_t state_d;

	logic [STEP_W-1:0]                step_q;
	logic [DVS_W-1:0]                 dvs_q;
	logic [NUM_CH-1:0][DVS_W-1:0]     rem_q;
	logic [NUM_CH-1:0][AVG_W-1:0]     quo_q;
	logic [TILE_IDX_W-1:0]            col_q;
	logic [TILE_IDX_W-1:0]            row_q;
	logic                             fd_q;

	logic                             load;
	logic                             run;
	logic [DVS_W-1:0]                 dvs_half;
	logic [NUM_CH-1:0][DVS_W-1:0]     rem_a;
	logic [NUM_CH-1:0][DVS_W-1:0]     rem_b;
	logic [NUM_CH-1:0][1:0]           qbits;

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (load) begin
					state_d = DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (step_q == STEP_W'(STEPS - 1)) begin
					state_d = DIV_DONE;
				end
			end
			DIV_DONE: begin
				if (load) begin
					state_d = DIV_RUN;
				end else if (out_ready) begin
					state_d = DIV_IDLE;
				end
			end
			default: begin
				state_d = DIV_IDLE;
			end
		endcase
	end

	always_comb begin
		job_ready = 1'b0;
		out_valid = 1'b0;
		run       = 1'b0;
		case (state_q)
			DIV_IDLE: begin
				job_ready = 1'b1;
			end
			DIV_RUN: begin
				run = 1'b1;
			end
			DIV_DONE: begin
				out_valid = 1'b1;
				job_ready = out_ready;
			end
			default: begin
				job_ready = 1'b0;
			end
		endcase
	end

	assign load     = job_ready && job_valid;
	assign dvs_half = dvs_q >> 1;

	// Two dependent compare-subtract steps per lane.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			qbits[c][1] = rem_q[c] >= dvs_q;
			rem_a[c]    = qbits[c][1] ? rem_q[c] - dvs_q : rem_q[c];
			qbits[c][0] = rem_a[c] >= dvs_half;
			rem_b[c]    = qbits[c][0] ? rem_a[c] - dvs_half : rem_a[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= '0;
			end else if (run) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvs_q <= DVS_W'(job.count) << (AVG_W - 1);
			col_q <= job.tile_col;
			row_q <= job.tile_row;
			fd_q  <= job.frame_done;
			for (int c = 0; c < NUM_CH; c++) begin
				rem_q[c] <= DVS_W'(job.sum[c]);
				quo_q[c] <= '0;
			end
		end else if (run) begin
			dvs_q <= dvs_q >> 2;
			for (int c = 0; c < NUM_CH; c++) begin
				rem_q[c] <= rem_b[c];
				quo_q[c] <= {quo_q[c][AVG_W-3:0], qbits[c]};
			end
		end
	end

	assign tile_col   = col_q;
	assign tile_row   = row_q;
	assign avg_red    = quo_q[0];
	assign avg_grn    = quo_q[1];
	assign avg_blu    = quo_q[2];
	assign frame_done = fd_q;

endmodule

`default_nettype wire

// ===== rtl/block_average_pixelate.sv =====
// Top level of the block-average mosaic pixelation block.
// Pixels enter in raster order, one word per clock while the tile queue has room.
// The front end tracks the raster position, keeps per-channel sums of the current
// tile row segment and folds them into a tile sum store (one entry per tile column,
// read at pixel accept and written back from the front stage, with forwarding).
// No clearing pass is needed: an entry is overwritten on each tile's first row.
// When a tile's last pixel arrives its sums and true pixel count go into a
// four-word queue. The divider takes one tile at a time: it loads the tile, runs
// four steps of two quotient bits each, then holds the result word until it is
// taken; this divider sets the sustained tile rate. Pixel input stalls only when
// the queue is full, so for tiles of 8 pixels width or more the stream runs at
// one pixel per clock while result words are taken at once. When nothing waits,
// a tile passes the front stage register, the queue and the divider steps before
// its result word turns valid. Writing image_width (index 0) or image_height
// (index 1) restarts the frame; a size of 0 reads as 1 and oversize saturates at
// MAX_WIDTH / MAX_HEIGHT. Write configuration only while idle.
`default_nettype none

`include "assert_macros.svh"

module block_average_pixelate import bap_pkg::*; #(
	parameter int BLOCK_SIZE = BAP_BLOCK_SIZE,
	parameter int MAX_WIDTH  = BAP_MAX_WIDTH,
	parameter int MAX_HEIGHT = BAP_MAX_HEIGHT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PIX_W-1:0]      red_in,
	input  wire logic [PIX_W-1:0]      green_in,
	input  wire logic [PIX_W-1:0]      blue_in,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [TILE_IDX_W-1:0]      tile_col,
	output logic [TILE_IDX_W-1:0]      tile_row,
	output logic [AVG_W-1:0]           avg_red,
	output logic [AVG_W-1:0]           avg_grn,
	output logic [AVG_W-1:0]           avg_blu,
	output logic                       frame_done
);

	bap_cfg_wr_t        cfg_wr;
	logic               job_valid;
	logic               job_ready;
	bap_job_t           job;
	logic               div_valid;
	logic               div_ready;
	bap_job_t           div_job;
	logic [QLVL_W-1:0]  q_level;

	// Register writes are taken on any cycle.
	assign cfg_ready    = 1'b1;
	assign cfg_wr.we    = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	bap_front #(
		.BLOCK_SIZE (BLOCK_SIZE),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	// Hold finished tiles while the divider is busy.
	bap_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_valid),
		.push_ready (job_ready),
		.push_job   (job),
		.pop_valid  (div_valid),
		.pop_ready  (div_ready),
		.pop_job    (div_job),
		.level      (q_level)
	);

	bap_divider u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (div_valid),
		.job_ready  (div_ready),
		.job        (div_job),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tile_col   (tile_col),
		.tile_row   (tile_row),
		.avg_red    (avg_red),
		.avg_grn    (avg_grn),
		.avg_blu    (avg_blu),
		.frame_done (frame_done)
	);

	`BAP_ASSERT_ALWAYS(a_queue_bound, q_level <= QLVL_W'(QUEUE_DEPTH), "tile queue overflow")
	`BAP_ASSERT_NEXT(a_push_held, job_valid && job_ready, q_level != '0, "pushed tile lost")
	`BAP_ASSERT_NEXT(a_one_result, out_valid && out_ready, !out_valid, "result word repeated")

endmodule

`default_nettype wire

// ===== tb/block_average_pixelate_tb.sv =====
// Self-checking testbench for the block-average pixelation block.
module block_average_pixelate_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bap_pkg::*;

	localparam int BS            = BAP_BLOCK_SIZE;
	localparam int TILE_COLS     = (BAP_MAX_WIDTH + BS - 1) / BS;
	localparam int SETTLE_CYCLES = 20;    // lets the last pixel clear the front stage
	localparam int IDLE_LIMIT    = 4000;  // cycles with no word moving on any channel
	localparam int RANDOM_ITEMS  = 1300;

	// Indexes outside the register list; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = {CFG_IDX_W{1'b1}};

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_t;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
	} pixel_t;

	// Channel sums of one tile row segment (at most BS pixels of 255).
	typedef struct packed {
		logic [10:0] r;
		logic [10:0] g;
		logic [10:0] b;
	} row_sum_t;

	// Channel sums of a whole tile (at most BS*BS pixels of 255).
	typedef struct packed {
		logic [13:0] r;
		logic [13:0] g;
		logic [13:0] b;
	} tile_sum_t;

	typedef struct packed {
		logic [TILE_IDX_W-1:0] col;
		logic [TILE_IDX_W-1:0] row;
		logic [AVG_W-1:0]      r;
		logic [AVG_W-1:0]      g;
		logic [AVG_W-1:0]      b;
		logic                  done;
	} tile_avg_t;

	// DUT ports; every input starts at a known value.
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      red_in    = '0;
	logic [PIX_W-1:0]      green_in  = '0;
	logic [PIX_W-1:0]      blue_in   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [TILE_IDX_W-1:0] tile_col;
	logic [TILE_IDX_W-1:0] tile_row;
	logic [AVG_W-1:0]      avg_red;
	logic [AVG_W-1:0]      avg_grn;
	logic [AVG_W-1:0]      avg_blu;
	logic                  frame_done;

	// Pixels waiting for the driver, and tiles the predictor expects next.
	pixel_t    pixel_q[$];
	tile_avg_t tile_avg_q[$];

	// Predictor copy of the block: sizes, raster position, running sums.
	logic [12:0] img_w   = 13'(BAP_MAX_WIDTH);
	logic [12:0] img_h   = 13'(BAP_MAX_HEIGHT);
	logic [11:0] pos_col = '0;
	logic [11:0] pos_row = '0;
	row_sum_t    run_sum = '0;
	tile_sum_t   col_sums[TILE_COLS];

	// Handshake flags of the last rising edge, read by the falling-edge processes.
	bit pix_taken = 1'b0;
	bit res_taken = 1'b0;
	bit cfg_taken = 1'b0;

	int errors        = 0;
	int pixels_in     = 0;
	int tiles_checked = 0;
	int frames_closed = 0;
	int reg_writes    = 0;
	int idle_cycles   = 0;

	// Sender burst shaping and receiver stall pattern.
	int       burst_left = 0;
	int       gap_left   = 0;
	int       rx_cycle   = 0;
	int       stall_left = 0;
	rx_mode_t rx_mode    = RX_ALWAYS;

	block_average_pixelate uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tile_col(tile_col),
		.tile_row(tile_row),
		.avg_red(avg_red),
		.avg_grn(avg_grn),
		.avg_blu(avg_blu),
		.frame_done(frame_done)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Size registers read 0 as 1 and saturate at the maximum.
	function automatic int clamp_dim(int v, int maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Bias channels toward the extremes so the flat-color averages show up too.
	function automatic logic [PIX_W-1:0] chan_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.r = chan_value();
		p.g = chan_value();
		p.b = chan_value();
		return p;
	endfunction

	// Large dimension: exact maximum, all ones, or values above or below the limit.
	function automatic int big_dim();
		case ($urandom_range(0, 3))
			0: return BAP_MAX_WIDTH;
			1: return 8191;
			2: return $urandom_range(4097, 8191);
			default: return $urandom_range(2000, 4095);
		endcase
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		errors++;
		$display("[%0t] mismatch on tile %0d: %0s got %0d expected %0d",
			$time, tiles_checked, what, got, want);
	endtask

	// Mirror a register write: size registers clamp and restart the frame.
	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] data);
		if (idx == REG_IMAGE_WIDTH) begin
			img_w = 13'(clamp_dim(int'(data), BAP_MAX_WIDTH));
		end else if (idx == REG_IMAGE_HEIGHT) begin
			img_h = 13'(clamp_dim(int'(data), BAP_MAX_HEIGHT));
		end else begin
			return;
		end
		pos_col = '0;
		pos_row = '0;
		run_sum = '0;
	endfunction

	// Fold one pixel into the tile sums; queue the averages when it closes a tile.
	function automatic void fold_pixel(pixel_t px);
		int        w, h, col, row, tc, tr, ic, ir, tw, th, cnt;
		bit        last_col, last_row;
		tile_avg_t t;
		w = int'(img_w);
		h = int'(img_h);
		if (int'(pos_col) >= w)
			pos_col = '0;
		if (int'(pos_row) >= h)
			pos_row = '0;
		col = int'(pos_col);
		row = int'(pos_row);
		tc = col / BS;
		tr = row / BS;
		ic = col % BS;
		ir = row % BS;
		if (ic == 0)
			run_sum = '0;
		run_sum.r += 11'(px.r);
		run_sum.g += 11'(px.g);
		run_sum.b += 11'(px.b);
		last_col = (col + 1 >= w);
		last_row = (row + 1 >= h);
		if ((last_col || ic == BS - 1) && tc < TILE_COLS) begin
			// first row of a tile overwrites the column entry, later rows add
			if (ir == 0) begin
				col_sums[tc].r = 14'(run_sum.r);
				col_sums[tc].g = 14'(run_sum.g);
				col_sums[tc].b = 14'(run_sum.b);
			end else begin
				col_sums[tc].r += 14'(run_sum.r);
				col_sums[tc].g += 14'(run_sum.g);
				col_sums[tc].b += 14'(run_sum.b);
			end
			if (last_row || ir == BS - 1) begin
				// edge tiles divide by their true, clipped pixel count
				tw = (w - tc * BS > BS) ? BS : w - tc * BS;
				th = (h - tr * BS > BS) ? BS : h - tr * BS;
				cnt = (tw * th == 0) ? 1 : tw * th;
				t.col = TILE_IDX_W'(tc);
				t.row = TILE_IDX_W'(tr);
				t.r = AVG_W'(int'(col_sums[tc].r) / cnt);
				t.g = AVG_W'(int'(col_sums[tc].g) / cnt);
				t.b = AVG_W'(int'(col_sums[tc].b) / cnt);
				t.done = last_col && last_row;
				tile_avg_q.push_back(t);
			end
		end
		if (last_col) begin
			pos_col = '0;
			pos_row = last_row ? '0 : 12'(row + 1);
		end else begin
			pos_col = 12'(col + 1);
		end
	endfunction

	// Compare the word on the output with the oldest expected tile.
	task automatic check_tile();
		tile_avg_t want;
		if (tile_avg_q.size() == 0) begin
			flag_mismatch("result with no tile pending, tile_col", int'(tile_col), -1);
			return;
		end
		want = tile_avg_q.pop_front();
		if (tile_col !== want.col)
			flag_mismatch("tile_col", int'(tile_col), int'(want.col));
		if (tile_row !== want.row)
			flag_mismatch("tile_row", int'(tile_row), int'(want.row));
		if (avg_red !== want.r)
			flag_mismatch("avg_red", int'(avg_red), int'(want.r));
		if (avg_grn !== want.g)
			flag_mismatch("avg_grn", int'(avg_grn), int'(want.g));
		if (avg_blu !== want.b)
			flag_mismatch("avg_blu", int'(avg_blu), int'(want.b));
		if (frame_done !== want.done)
			flag_mismatch("frame_done", int'(frame_done), int'(want.done));
		tiles_checked++;
		if (want.done)
			frames_closed++;
	endtask

	// Monitor: sample every channel at the rising edge.
	// Register writes apply first so the predictor sees the new size before any pixel.
	always @(posedge clk) begin
		if (arst_n) begin
			pix_taken = in_valid && in_ready;
			res_taken = out_valid && out_ready;
			cfg_taken = cfg_valid && cfg_ready;
			if (cfg_taken) begin
				apply_reg_write(cfg_index, cfg_data);
				reg_writes++;
			end
			if (res_taken)
				check_tile();
			if (pix_taken) begin
				fold_pixel('{red_in, green_in, blue_in});
				pixels_in++;
			end
		end
	end

	// Driver: hold a word until taken, then advance from the queue.
	// Bursts of random length alternate with gaps; zero-length gaps chain bursts
	// into long stretches at full rate.
	always @(negedge clk) begin
		pixel_t px;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !pix_taken) begin
			// hold the current word
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pixel_q.size() != 0) begin
			px = pixel_q.pop_front();
			red_in <= px.r;
			green_in <= px.g;
			blue_in <= px.b;
			in_valid <= 1'b1;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 40);
				case ($urandom_range(0, 9))
					0, 1, 2: gap_left = 0;
					3, 4, 5, 6, 7: gap_left = $urandom_range(1, 4);
					default: gap_left = $urandom_range(5, 20);
				endcase
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: drive out_ready from a stall pattern that is re-picked at random.
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 7);
			RX_PERIODIC: out_ready <= ((rx_cycle % 7) < 4);
			default: begin
				// long stalls back the result queue up into the pixel input
				if (stall_left > 0) begin
					stall_left--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						stall_left = $urandom_range(5, 15);
				end
			end
		endcase
	end

	// Watchdog: end the run when no word moves on any channel for too long.
	always @(negedge clk) begin
		if (pix_taken || res_taken || cfg_taken)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("block_average_pixelate regression: fail");
			$finish;
		end
	end

	// Present one register word and drop valid once the monitor has seen it taken.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		int seen;
		@(negedge clk);
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(val);
		cfg_valid = 1'b1;
		seen = reg_writes;
		wait (reg_writes != seen);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait until the driver has handed over every pixel and every tile has come out.
	task automatic wait_results();
		while (pixel_q.size() != 0 || in_valid)
			@(posedge clk);
		while (tile_avg_q.size() != 0)
			@(posedge clk);
	endtask

	// Pixels that close no tile may still be in flight; let them drain too.
	task automatic go_idle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_pixels(int n);
		for (int i = 0; i < n; i++)
			pixel_q.push_back(rand_pixel());
	endtask

	initial begin
		int w, h, n, half, frame_px, pick, wsel;
		int cur_w, cur_h, phase_cnt, random_items;
		bit paused;
		phase_cnt = 0;
		random_items = 0;
		paused = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero size reads as 1x1: every pixel is a full frame of its own.
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 0);
		pixel_q.push_back('{8'hFF, 8'hFF, 8'hFF});
		pixel_q.push_back('{8'h00, 8'h00, 8'h00});
		pixel_q.push_back('{8'h55, 8'hAA, 8'h0F});
		pixel_q.push_back('{8'hAA, 8'h55, 8'hF0});
		go_idle();

		// Oversize width saturates; one row, so each 8 pixels close a tile.
		// The write after this cuts the second tile short mid-frame.
		write_reg(REG_IMAGE_WIDTH, 8191);
		write_reg(REG_IMAGE_HEIGHT, 1);
		for (int i = 0; i < 12; i++)
			pixel_q.push_back('{PIX_W'(i * 23), PIX_W'(255 - i * 21), PIX_W'(i * i)});
		go_idle();

		// 3x2 frame split by a write to an unmapped index, which must not restart it.
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 2);
		push_pixels(3);
		go_idle();
		write_reg(REG_UNMAPPED_LO, 13'h0ABC);
		push_pixels(3);
		cur_w = 3;
		cur_h = 2;

		// Random phases: mostly small frames, some wider ones, a few extreme shapes.
		while (random_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24);
				h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24);
			end else if (pick == 6) begin
				w = big_dim();
				h = $urandom_range(0, 1);
			end else if (pick == 7) begin
				w = $urandom_range(0, 5);
				h = big_dim();
			end else begin
				w = $urandom_range(25, 100);
				h = $urandom_range(1, 16);
			end

			go_idle();
			if ($urandom_range(0, 5) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
					$urandom_range(0, 8191));
			// sometimes write one register only, so the other one carries over
			wsel = $urandom_range(0, 5);
			if (wsel == 1) begin
				write_reg(REG_IMAGE_HEIGHT, h);
			end else if (wsel == 2) begin
				write_reg(REG_IMAGE_HEIGHT, h);
				write_reg(REG_IMAGE_WIDTH, w);
			end else begin
				write_reg(REG_IMAGE_WIDTH, w);
				if (wsel != 0)
					write_reg(REG_IMAGE_HEIGHT, h);
			end
			if (wsel != 1)
				cur_w = clamp_dim(w, BAP_MAX_WIDTH);
			if (wsel != 0)
				cur_h = clamp_dim(h, BAP_MAX_HEIGHT);

			// whole frames (wrap to top-left) plus at times a cut-off partial frame; large frames only a part
			frame_px = cur_w * cur_h;
			if (frame_px <= 600) begin
				n = frame_px * $urandom_range(1, 3);
				if (frame_px > 1 && $urandom_range(0, 3) == 0)
					n += $urandom_range(1, frame_px - 1);
			end else begin
				n = $urandom_range(60, 250);
			end
			// stay near the planned pixel count
			if (n > RANDOM_ITEMS - random_items)
				n = RANDOM_ITEMS - random_items;

			// sender holds off mid-frame until every pending tile is out
			if (n > 1 && (!paused || $urandom_range(0, 4) == 0)) begin
				paused = 1'b1;
				half = n / 2;
				push_pixels(half);
				wait_results();
				push_pixels(n - half);
			end else begin
				push_pixels(n);
			end
			random_items += n;
			phase_cnt++;
		end

		go_idle();
		if (tile_avg_q.size() != 0)
			flag_mismatch("tiles never produced", 0, tile_avg_q.size());

		$display("run covered %0d pixels in %0d random size settings, %0d register writes",
			pixels_in, phase_cnt, reg_writes);
		$display("checked %0d tile averages, %0d closing a frame; %0d mismatches",
			tiles_checked, frames_closed, errors);
		if (errors == 0)
			$display("block_average_pixelate regression: pass");
		else
			$display("block_average_pixelate regression: fail");
		$finish;
	end

endmodule

// ===== block_average_pixelate.f =====
+incdir+rtl
rtl/bap_pkg.sv
rtl/bap_front.sv
rtl/bap_fifo.sv
rtl/bap_divider.sv
rtl/block_average_pixelate.sv
tb/block_average_pixelate_tb.sv
